// ===== rtl/vrpd_pkg.sv =====
// Package with payload types, register indexes, cell codes and sequencer codes of the dropout unit.
package vrpd_pkg;

   localparam int COORD_W      = 16;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 17;
   localparam int CELL_IDX_W   = 15;
   localparam int KEPT_TOTAL_W = 21;
   localparam int VOXEL_DIM_W  = 6;
   localparam int THRESHOLD_W  = 17;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_VOXEL_DIM      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_THRESHOLD = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X          = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Y          = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Z          = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X        = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y        = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Z        = 4'd7;

   // Register reset values.
   localparam logic [VOXEL_DIM_W-1:0] VOXEL_DIM_RESET = 6'd32;
   localparam logic [COORD_W-1:0]     SCALE_RESET     = 16'd256;

   // Per-cell decision codes.
   localparam logic [1:0] CELL_UNDECIDED = 2'd0;
   localparam logic [1:0] CELL_KEEP      = 2'd1;
   localparam logic [1:0] CELL_DROP      = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [COORD_W-1:0]        random_word;
      logic                      first_point;
      logic                      last_point;
   } vrpd_req_type;

   typedef struct packed {
      logic                    keep;
      logic [CELL_IDX_W-1:0]   cell_index;
      logic                    force_first;
      logic [KEPT_TOTAL_W-1:0] kept_total;
      logic                    end_of_run;
   } vrpd_rsp_type;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_MAC    = 7'b0000100,
      S_MOD    = 7'b0001000,
      S_READ   = 7'b0010000,
      S_LOOKUP = 7'b0100000,
      S_FORCE  = 7'b1000000
   } vrpd_state_type;

   // Operations of the shared multiply-accumulate unit, in issue order.
   typedef enum logic [2:0] {
      STEP_CX   = 3'd0,
      STEP_CY   = 3'd1,
      STEP_CZ   = 3'd2,
      STEP_SQ   = 3'd3,
      STEP_CUBE = 3'd4,
      STEP_ROW  = 3'd5,
      STEP_IDX  = 3'd6
   } vrpd_step_type;

endpackage

// ===== rtl/voxel_random_point_dropout_unit.sv =====
// Top level of the voxel random point dropout unit: sequencer, shared MAC, remainder unit and cell table.
//
//   Channel   Direction   Ports                                   Moves
//   req       in          req_valid, req_ready, req_payload       one point request
//   rsp       out         rsp_valid, rsp_ready, rsp_payload       one or two results per request
//   csr       in          csr_valid, csr_ready, csr_index/wdata   one register write
//
// Each point passes through the accept cycle, seven passes through the shared multiply-accumulate
// unit, one restoring remainder step per bit of the TW-bit index word (TW = 18 + 2*clog2(MAX_DIM+1)),
// a table read and a lookup before the next request is accepted. A forced keep adds a second
// result from its own state before the unit returns to idle.
// After reset, and after accepting a request that marks the first point of a cloud, a clearing
// pass writes every one of the MAX_DIM**3 table entries (32768 at the default), one per cycle.
// Reset is synchronous and active high. A stalled rsp holds the finished result in the output
// register while the next request is taken; the lookup waits only if that register is still full.
module voxel_random_point_dropout_unit
   import vrpd_pkg::*;
#(
   parameter int MAX_DIM    = 32,
   parameter int MAX_POINTS = 1048576
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vrpd_req_type          req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vrpd_rsp_type          rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Width of an effective dimension, of dim cubed, of the MAC operands and of the flat index.
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int CELLW = 3 * DW;
   localparam int MA    = COORD_W + DW + 1;
   localparam int MPW   = MA + COORD_W;
   localparam int PW    = MPW + 1;
   localparam int TW    = COORD_W + 2 * DW + 2;
   localparam int BW    = $clog2(TW);
   localparam int TBL   = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int ADW   = (TBL > 1) ? $clog2(TBL) : 1;
   localparam int KW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS + 1) : 1;
   localparam int KTW   = (KW > KEPT_TOTAL_W) ? KW : KEPT_TOTAL_W;
   localparam int IXW   = (CELLW > CELL_IDX_W) ? CELLW : CELL_IDX_W;

   // Clamped difference pos - min: zero or negative differences give cell coordinate zero.
   function automatic logic [COORD_W-1:0] clamp_diff(input logic signed [COORD_W-1:0] pos,
                                                     input logic signed [COORD_W-1:0] lo);
      logic signed [COORD_W:0] d;
      d = {pos[COORD_W-1], pos} - {lo[COORD_W-1], lo};
      return (d <= 0) ? '0 : d[COORD_W-1:0];
   endfunction

   // Configuration registers.
   logic [VOXEL_DIM_W-1:0]    voxel_dim_ff;
   logic [THRESHOLD_W-1:0]    drop_threshold_ff;
   logic signed [COORD_W-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic [COORD_W-1:0]        scale_x_ff, scale_y_ff, scale_z_ff;

   // Control state.
   vrpd_state_type   state_ff, state_in;
   vrpd_step_type    step_ff, step_in;
   logic [BW-1:0]    bit_ff, bit_in;
   logic [ADW-1:0]   clr_ff, clr_in;
   logic             pend_ff, pend_in;
   logic [KW-1:0]    kept_ff, kept_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   vrpd_req_type       item_ff, item_in;
   vrpd_rsp_type       rsp_ff, rsp_in;
   logic [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [DW-1:0]      dim_ff, dim_in;
   logic [CELLW-1:0]   cells_ff, cells_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [CELLW-1:0]   rem_ff, rem_in;
   logic [1:0]         rd_ff;

   // Cell table and its ports.
   logic [1:0]   cell_mem [TBL];
   logic         mem_we;
   logic         mem_re;
   logic [ADW-1:0] mem_wa;
   logic [1:0]   mem_wd;

   // Combinational helpers.
   logic [DW-1:0]      dim_eff;
   logic [MA-1:0]      mac_a;
   logic [COORD_W-1:0] mac_b;
   logic [COORD_W-1:0] mac_c;
   logic [MPW-1:0]     mac_prod;
   logic [PW-1:0]      mac_sum;
   logic [CELLW:0]     mod_shift;
   logic [CELLW-1:0]   mod_rem;
   logic               undecided;
   logic [1:0]         new_dec;
   logic [1:0]         dec_eff;
   logic               keep_pt;
   logic [KW-1:0]      kept_next;
   logic               force_run;
   logic [KTW-1:0]     kept_wide;
   logic [IXW-1:0]     idx_wide;
   logic               out_free;

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Configuration writes; indexes past the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         voxel_dim_ff      <= VOXEL_DIM_RESET;
         drop_threshold_ff <= '0;
         min_x_ff          <= '0;
         min_y_ff          <= '0;
         min_z_ff          <= '0;
         scale_x_ff        <= SCALE_RESET;
         scale_y_ff        <= SCALE_RESET;
         scale_z_ff        <= SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VOXEL_DIM:      voxel_dim_ff      <= csr_wdata[VOXEL_DIM_W-1:0];
            CSR_DROP_THRESHOLD: drop_threshold_ff <= csr_wdata[THRESHOLD_W-1:0];
            CSR_MIN_X:          min_x_ff          <= csr_wdata[COORD_W-1:0];
            CSR_MIN_Y:          min_y_ff          <= csr_wdata[COORD_W-1:0];
            CSR_MIN_Z:          min_z_ff          <= csr_wdata[COORD_W-1:0];
            CSR_SCALE_X:        scale_x_ff        <= csr_wdata[COORD_W-1:0];
            CSR_SCALE_Y:        scale_y_ff        <= csr_wdata[COORD_W-1:0];
            CSR_SCALE_Z:        scale_z_ff        <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // A dimension of zero acts as one; values above MAX_DIM saturate.
   always_comb begin
      if (voxel_dim_ff == '0) begin
         dim_eff = DW'(1);
      end else if (int'(voxel_dim_ff) > MAX_DIM) begin
         dim_eff = DW'(MAX_DIM);
      end else begin
         dim_eff = DW'(voxel_dim_ff);
      end
   end

   // Shared multiply-accumulate unit. The sequence is: the three cell coordinates
   // (diff * scale, upper half), dim squared, dim cubed, then the flat index
   // (cx * dim + cy) * dim + cz in two passes.
   always_comb begin
      mac_a = '0;
      mac_b = '0;
      mac_c = '0;
      case (step_ff)
         STEP_CX: begin
            mac_a = MA'(dx_ff);
            mac_b = scale_x_ff;
         end
         STEP_CY: begin
            mac_a = MA'(dy_ff);
            mac_b = scale_y_ff;
         end
         STEP_CZ: begin
            mac_a = MA'(dz_ff);
            mac_b = scale_z_ff;
         end
         STEP_SQ: begin
            mac_a = MA'(dim_ff);
            mac_b = COORD_W'(dim_ff);
         end
         STEP_CUBE: begin
            mac_a = MA'(cells_ff);
            mac_b = COORD_W'(dim_ff);
         end
         STEP_ROW: begin
            mac_a = MA'(cx_ff);
            mac_b = COORD_W'(dim_ff);
            mac_c = cy_ff;
         end
         STEP_IDX: begin
            mac_a = t_ff[MA-1:0];
            mac_b = COORD_W'(dim_ff);
            mac_c = cz_ff;
         end
         default: ;
      endcase
      mac_prod = mac_a * mac_b;
      mac_sum  = PW'(mac_prod) + PW'(mac_c);
   end

   // One restoring remainder step per cycle: the index word shifts in MSB first.
   always_comb begin
      mod_shift = {rem_ff, t_ff[TW-1]};
      if (mod_shift >= {1'b0, cells_ff}) begin
         mod_rem = CELLW'(mod_shift - {1'b0, cells_ff});
      end else begin
         mod_rem = mod_shift[CELLW-1:0];
      end
   end

   // Cell decision: the first point in a cell draws it from its random word.
   always_comb begin
      undecided = (rd_ff == CELL_UNDECIDED);
      new_dec   = ({1'b0, item_ff.random_word} < drop_threshold_ff) ? CELL_DROP : CELL_KEEP;
      dec_eff   = undecided ? new_dec : rd_ff;
      keep_pt   = (dec_eff == CELL_KEEP);
      if (keep_pt && (kept_ff < KW'(MAX_POINTS))) begin
         kept_next = kept_ff + KW'(1);
      end else begin
         kept_next = kept_ff;
      end
      force_run = item_ff.last_point && (kept_next == '0);
      kept_wide = KTW'(kept_next);
      idx_wide  = IXW'(rem_ff);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      kept_in      = kept_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      dim_in       = dim_ff;
      cells_in     = cells_ff;
      t_in         = t_ff;
      rem_in       = rem_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wa       = clr_ff;
      mem_wd       = CELL_UNDECIDED;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep the whole table back to undecided.
            mem_we = 1'b1;
            if (clr_ff == ADW'(TBL - 1)) begin
               clr_in  = '0;
               pend_in = 1'b0;
               step_in = STEP_CX;
               state_in = pend_ff ? S_MAC : S_IDLE;
            end else begin
               clr_in = clr_ff + ADW'(1);
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               item_in = req_payload;
               dx_in   = clamp_diff(req_payload.pos_x, min_x_ff);
               dy_in   = clamp_diff(req_payload.pos_y, min_y_ff);
               dz_in   = clamp_diff(req_payload.pos_z, min_z_ff);
               dim_in  = dim_eff;
               step_in = STEP_CX;
               if (req_payload.first_point) begin
                  kept_in  = '0;
                  pend_in  = 1'b1;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_MAC;
               end
            end
         end

         S_MAC: begin
            case (step_ff)
               STEP_CX: begin
                  cx_in   = mac_sum[2*COORD_W-1:COORD_W];
                  step_in = STEP_CY;
               end
               STEP_CY: begin
                  cy_in   = mac_sum[2*COORD_W-1:COORD_W];
                  step_in = STEP_CZ;
               end
               STEP_CZ: begin
                  cz_in   = mac_sum[2*COORD_W-1:COORD_W];
                  step_in = STEP_SQ;
               end
               STEP_SQ: begin
                  cells_in = mac_sum[CELLW-1:0];
                  step_in  = STEP_CUBE;
               end
               STEP_CUBE: begin
                  cells_in = mac_sum[CELLW-1:0];
                  step_in  = STEP_ROW;
               end
               STEP_ROW: begin
                  t_in    = mac_sum[TW-1:0];
                  step_in = STEP_IDX;
               end
               STEP_IDX: begin
                  t_in     = mac_sum[TW-1:0];
                  rem_in   = '0;
                  bit_in   = BW'(TW - 1);
                  state_in = S_MOD;
               end
               default: step_in = STEP_CX;
            endcase
         end

         S_MOD: begin
            rem_in = mod_rem;
            t_in   = t_ff << 1;
            if (bit_ff == '0) begin
               state_in = S_READ;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end

         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_LOOKUP;
         end

         S_LOOKUP: begin
            // Wait here until the output register can take the result.
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.keep        = keep_pt;
               rsp_in.cell_index  = idx_wide[CELL_IDX_W-1:0];
               rsp_in.force_first = 1'b0;
               rsp_in.kept_total  = kept_wide[KEPT_TOTAL_W-1:0];
               rsp_in.end_of_run  = !force_run;
               mem_we             = undecided;
               mem_wa             = rem_ff[ADW-1:0];
               mem_wd             = new_dec;
               if (force_run) begin
                  kept_in  = KW'(1);
                  state_in = S_FORCE;
               end else begin
                  kept_in  = kept_next;
                  state_in = S_IDLE;
               end
            end
         end

         S_FORCE: begin
            // Nothing kept by the end of the cloud: point 0 is kept instead.
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.keep        = 1'b1;
               rsp_in.cell_index  = '0;
               rsp_in.force_first = 1'b1;
               rsp_in.kept_total  = KEPT_TOTAL_W'(1);
               rsp_in.end_of_run  = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= STEP_CX;
         bit_ff       <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      rsp_ff   <= rsp_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      dim_ff   <= dim_in;
      cells_ff <= cells_in;
      t_ff     <= t_in;
      rem_ff   <= rem_in;
   end

   // Cell table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= cell_mem[rem_ff[ADW-1:0]];
      end
   end

endmodule

// ===== test/tb_voxel_random_point_dropout_unit.sv =====
// Self-checking testbench for the voxel random point dropout unit.
`timescale 1ns / 1ps

module tb_voxel_random_point_dropout_unit;
   import vrpd_pkg::*;

   // The unit is built with its default grid and count limits.
   localparam int MAX_DIM         = 32;
   localparam int MAX_POINTS      = 1048576;
   localparam int GRID_CELLS      = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int LONG_HOLD       = 600;
   localparam int TAIL_CYCLES     = 200;
   localparam int REPORT_LIMIT    = 10;
   // A single request may wait behind a whole clearing pass, a point computation and a long
   // result stall. The limit is several times that worst stretch without any handshake.
   localparam int WATCHDOG_LIMIT  = 4 * (GRID_CELLS + 64 + LONG_HOLD);

   // Scoreboard: it keeps its own copy of the registers, the per-cell decisions and the kept
   // count, works out the verdicts of each accepted request and checks the results in order.
   class dropout_scoreboard;
      logic [1:0]                cell_state [GRID_CELLS];
      int unsigned               kept_count;
      logic [VOXEL_DIM_W-1:0]    voxel_dim;
      logic [THRESHOLD_W-1:0]    drop_threshold;
      logic signed [COORD_W-1:0] min_pos [3];
      logic [COORD_W-1:0]        scale [3];
      vrpd_rsp_type              pending_verdicts [$];
      int                        mismatch_count;
      int                        request_count;
      int                        result_count;
      int                        write_count;
      int                        kept_seen;
      int                        dropped_seen;
      int                        forced_seen;

      function new();
         voxel_dim = VOXEL_DIM_RESET;
         drop_threshold = '0;
         foreach (min_pos[a]) begin
            min_pos[a] = '0;
            scale[a] = SCALE_RESET;
         end
         foreach (cell_state[i]) cell_state[i] = CELL_UNDECIDED;
         kept_count = 0;
      endfunction

      function void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         write_count++;
         case (idx)
            CSR_VOXEL_DIM:      voxel_dim = data[VOXEL_DIM_W-1:0];
            CSR_DROP_THRESHOLD: drop_threshold = data[THRESHOLD_W-1:0];
            CSR_MIN_X:          min_pos[0] = data[COORD_W-1:0];
            CSR_MIN_Y:          min_pos[1] = data[COORD_W-1:0];
            CSR_MIN_Z:          min_pos[2] = data[COORD_W-1:0];
            CSR_SCALE_X:        scale[0] = data[COORD_W-1:0];
            CSR_SCALE_Y:        scale[1] = data[COORD_W-1:0];
            CSR_SCALE_Z:        scale[2] = data[COORD_W-1:0];
            default: ;
         endcase
      endfunction

      // Grid coordinate along one axis; points at or below the box minimum land in cell 0.
      function longint unsigned cell_coord(logic signed [COORD_W-1:0] pos,
                                           logic signed [COORD_W-1:0] lo,
                                           logic [COORD_W-1:0] sc);
         int d;
         d = int'(pos) - int'(lo);
         if (d <= 0) return 0;
         return (longint'(d) * longint'(sc)) >> 16;
      endfunction

      function void note_request(vrpd_req_type p);
         longint unsigned dim_eff, cells, cx, cy, cz, idx;
         logic [1:0]      decision;
         vrpd_rsp_type    v;
         request_count++;
         dim_eff = voxel_dim;
         if (dim_eff == 0) dim_eff = 1;
         if (dim_eff > MAX_DIM) dim_eff = MAX_DIM;
         cells = dim_eff * dim_eff * dim_eff;
         if (p.first_point) begin
            foreach (cell_state[i]) cell_state[i] = CELL_UNDECIDED;
            kept_count = 0;
         end
         cx = cell_coord(p.pos_x, min_pos[0], scale[0]);
         cy = cell_coord(p.pos_y, min_pos[1], scale[1]);
         cz = cell_coord(p.pos_z, min_pos[2], scale[2]);
         idx = ((cx * dim_eff + cy) * dim_eff + cz) % cells;
         decision = cell_state[idx];
         if (decision == CELL_UNDECIDED) begin
            decision = (p.random_word < drop_threshold) ? CELL_DROP : CELL_KEEP;
            cell_state[idx] = decision;
         end
         if (decision == CELL_KEEP) begin
            kept_seen++;
            if (kept_count < MAX_POINTS) kept_count++;
         end else begin
            dropped_seen++;
         end
         v.keep        = (decision == CELL_KEEP);
         v.cell_index  = idx[CELL_IDX_W-1:0];
         v.force_first = 1'b0;
         v.kept_total  = kept_count[KEPT_TOTAL_W-1:0];
         v.end_of_run  = 1'b1;
         if (p.last_point && kept_count == 0) begin
            // Nothing survived the cloud: a second result keeps point 0.
            v.end_of_run = 1'b0;
            pending_verdicts.push_back(v);
            kept_count = 1;
            forced_seen++;
            v.keep        = 1'b1;
            v.cell_index  = '0;
            v.force_first = 1'b1;
            v.kept_total  = KEPT_TOTAL_W'(1);
            v.end_of_run  = 1'b1;
         end
         pending_verdicts.push_back(v);
      endfunction

      function void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result %0d, %s expected %0h, got %0h",
                     $time, result_count, what, want, got);
      endfunction

      function void check_result(vrpd_rsp_type r);
         vrpd_rsp_type want;
         result_count++;
         if (pending_verdicts.size() == 0) begin
            flag_mismatch("unexpected result, keep", 'x, 32'(r.keep));
            return;
         end
         want = pending_verdicts.pop_front();
         if (r.keep !== want.keep) flag_mismatch("keep", 32'(want.keep), 32'(r.keep));
         if (r.cell_index !== want.cell_index)
            flag_mismatch("cell_index", 32'(want.cell_index), 32'(r.cell_index));
         if (r.force_first !== want.force_first)
            flag_mismatch("force_first", 32'(want.force_first), 32'(r.force_first));
         if (r.kept_total !== want.kept_total)
            flag_mismatch("kept_total", 32'(want.kept_total), 32'(r.kept_total));
         if (r.end_of_run !== want.end_of_run)
            flag_mismatch("end_of_run", 32'(want.end_of_run), 32'(r.end_of_run));
      endfunction

      function int outstanding();
         return pending_verdicts.size();
      endfunction
   endclass

   // Every input of the unit starts at a known value; reset is held from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   vrpd_req_type          req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   vrpd_rsp_type          rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   dropout_scoreboard sb;

   // Idle rates in percent per cycle, set by the main sequence for each stretch of the run.
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;

   // The main sequence asks for a long result stall by bumping hold_requests; the receiver
   // process serves each request once and counts the stall down on its own.
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int stall_cycles  = 0;
   int settings_count = 0;

   // Settings currently in force, used only to aim the random points at the grid.
   int cur_dim;
   int cur_min [3];
   int cur_scale [3];
   vrpd_req_type recent_points [$];

   voxel_random_point_dropout_unit #(
      .MAX_DIM    (MAX_DIM),
      .MAX_POINTS (MAX_POINTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side. Ready is drawn fresh every cycle from the current idle rate, except during a
   // long stall, when it stays low so that the unit backs up into its request port.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // All handshakes are sampled at the rising edge, before the edge's own updates land.
   // Results are checked before the request of the same edge is noted; the two never
   // refer to each other since a result always trails its request through the sequencer states.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_payload);
         if (req_valid && req_ready) sb.note_request(req_payload);
         if (csr_valid && csr_ready) sb.apply_write(csr_index, csr_wdata);
      end
   end

   // Watchdog: any handshake restarts the count. Reaching the limit means the unit hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results still due",
                  $time, stall_cycles, sb.outstanding());
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one request and return at the edge where it is taken. Valid stays high into the
   // next request unless a gap is drawn, so it is never lowered and raised in one step.
   task automatic send_point(vrpd_req_type p);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering requests and wait until every result due has been taken. It first waits for a
   // rising edge so that the monitor has noted the last request.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write every register while the unit is idle. Bits above each register's width carry
   // random junk, which the unit must drop, and one write goes to an index past the list.
   task automatic apply_settings(int dim, int thr, int mx, int my, int mz,
                                 int sx, int sy, int sz);
      logic [CSR_DATA_W-1:0] data;
      cur_dim = dim;
      cur_min[0] = mx;
      cur_min[1] = my;
      cur_min[2] = mz;
      cur_scale[0] = sx;
      cur_scale[1] = sy;
      cur_scale[2] = sz;
      data = CSR_DATA_W'($urandom);
      data[VOXEL_DIM_W-1:0] = dim[VOXEL_DIM_W-1:0];
      write_register(CSR_VOXEL_DIM, data);
      write_register(CSR_DROP_THRESHOLD, thr[CSR_DATA_W-1:0]);
      data = CSR_DATA_W'($urandom);
      data[COORD_W-1:0] = mx[COORD_W-1:0];
      write_register(CSR_MIN_X, data);
      data[COORD_W-1:0] = my[COORD_W-1:0];
      write_register(CSR_MIN_Y, data);
      data[COORD_W-1:0] = mz[COORD_W-1:0];
      write_register(CSR_MIN_Z, data);
      data = CSR_DATA_W'($urandom);
      data[COORD_W-1:0] = sx[COORD_W-1:0];
      write_register(CSR_SCALE_X, data);
      data[COORD_W-1:0] = sy[COORD_W-1:0];
      write_register(CSR_SCALE_Y, data);
      data[COORD_W-1:0] = sz[COORD_W-1:0];
      write_register(CSR_SCALE_Z, data);
      write_register(CSR_IDX_W'(CSR_SCALE_Z + 1 + $urandom_range(7)),
                     CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   function automatic vrpd_req_type point_at(int x, int y, int z, int rw, bit first, bit last);
      vrpd_req_type p;
      p.pos_x = x[COORD_W-1:0];
      p.pos_y = y[COORD_W-1:0];
      p.pos_z = z[COORD_W-1:0];
      p.random_word = rw[COORD_W-1:0];
      p.first_point = first;
      p.last_point = last;
      return p;
   endfunction

   // Coordinate aimed a little past the grid along one axis, so that most points land inside,
   // some wrap through the modulo and a few fall below the box minimum.
   function automatic logic [COORD_W-1:0] pick_coord(int axis);
      int dim_eff, span, d, pos;
      dim_eff = (cur_dim == 0) ? 1 : ((cur_dim > MAX_DIM) ? MAX_DIM : cur_dim);
      span = (cur_scale[axis] == 0) ? 512 : (dim_eff * 81920) / cur_scale[axis];
      if (span > 65535) span = 65535;
      if (span < 1) span = 1;
      if ($urandom_range(19) == 0) d = -int'($urandom_range(300));
      else d = $urandom_range(span);
      pos = cur_min[axis] + d;
      if (pos > 32767) pos = 32767;
      if (pos < -32768) pos = -32768;
      return pos[COORD_W-1:0];
   endfunction

   // A point of a well-formed cloud. About a third reuse a recent position so that cells
   // already decided are visited again with a fresh random word.
   function automatic vrpd_req_type shaped_point(bit first, bit last);
      vrpd_req_type p;
      if (recent_points.size() != 0 && $urandom_range(9) < 3) begin
         p = recent_points[$urandom_range(recent_points.size() - 1)];
      end else begin
         p.pos_x = pick_coord(0);
         p.pos_y = pick_coord(1);
         p.pos_z = pick_coord(2);
      end
      p.random_word = COORD_W'($urandom_range(65535));
      p.first_point = first;
      p.last_point = last;
      recent_points.push_back(p);
      if (recent_points.size() > 16) void'(recent_points.pop_front());
      return p;
   endfunction

   // Noise: any coordinates, a stray end of cloud now and then, and rarely a new cloud.
   function automatic vrpd_req_type noise_point();
      vrpd_req_type p;
      p.pos_x = COORD_W'($urandom);
      p.pos_y = COORD_W'($urandom);
      p.pos_z = COORD_W'($urandom);
      p.random_word = COORD_W'($urandom);
      p.first_point = ($urandom_range(99) == 0);
      p.last_point = ($urandom_range(3) == 0);
      return p;
   endfunction

   function automatic int random_min();
      return int'($urandom_range(4000)) - 2000;
   endfunction

   function automatic int random_scale();
      return $urandom_range(64, 8192);
   endfunction

   // Clouds of random length. Most open with a first point; the others carry on the cloud
   // before them, table and count included.
   task automatic run_phase(int n_items);
      int sent, cloud_len, k;
      bit opens_cloud;
      vrpd_req_type p;
      sent = 0;
      while (sent < n_items) begin
         cloud_len = $urandom_range(40, 200);
         opens_cloud = ($urandom_range(4) != 0);
         recent_points.delete();
         for (k = 0; k < cloud_len && sent < n_items; k++) begin
            if ($urandom_range(9) == 0) p = noise_point();
            else p = shaped_point(opens_cloud && k == 0, k == cloud_len - 1);
            send_point(p);
            sent++;
         end
      end
   endtask

   // Settings per random phase; phase 0 uses the reset values and phases 2 and 4 hit the extremes of the registers.
   task automatic pick_settings(int phase_no);
      case (phase_no)
         0: apply_settings(32, 0, 0, 0, 0, 256, 256, 256);
         1: apply_settings(3, 32768, random_min(), random_min(), random_min(),
                           random_scale(), random_scale(), random_scale());
         2: apply_settings(1, 65536, -32768, -32768, -32768, 65535, 65535, 65535);
         3: apply_settings($urandom_range(2, 8), $urandom_range(65535),
                           random_min(), random_min(), random_min(),
                           random_scale(), random_scale(), random_scale());
         4: apply_settings(0, 131071, 32767, 32767, 32767, 0, 0, 0);
         5: apply_settings($urandom_range(33, 63), $urandom_range(65535),
                           random_min(), random_min(), random_min(),
                           random_scale(), random_scale(), random_scale());
         6: apply_settings($urandom_range(1, 32), $urandom_range(65535),
                           random_min(), random_min(), random_min(),
                           random_scale(), random_scale(), random_scale());
         default: apply_settings($urandom_range(1, 8), $urandom_range(50000, 70000),
                                 random_min(), random_min(), random_min(),
                                 random_scale(), random_scale(), random_scale());
      endcase
   endtask

   initial begin
      int phase_no;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The first stretch idles the sender lightly and the receiver heavily.
      send_idle_pct = 6;
      rcv_idle_pct = 47;

      // Small grid with a half threshold: far corner wrapping through the modulo, a revisit
      // of the same cell with the opposite random word, clamping below the box, a point
      // exactly at the minimum, and random words just below and equal to the threshold.
      apply_settings(4, 32768, -256, -256, -256, 256, 256, 256);
      send_point(point_at(32767, 32767, 32767, 0, 1'b1, 1'b0));
      send_point(point_at(32767, 32767, 32767, 65535, 1'b0, 1'b0));
      send_point(point_at(-32768, -32768, -32768, 65535, 1'b0, 1'b0));
      send_point(point_at(-256, -256, -256, 0, 1'b0, 1'b0));
      send_point(point_at(0, -256, -256, 32767, 1'b0, 1'b0));
      send_point(point_at(-256, 0, -256, 32768, 1'b0, 1'b1));
      wait_for_results();

      // Dimension zero acts as a single cell and every new cell drops, so the end of the
      // cloud forces a keep. The points after it continue the same cloud.
      apply_settings(0, 65536, 0, 0, 0, 65535, 65535, 65535);
      send_point(point_at(100, -5, 7, 65535, 1'b1, 1'b0));
      send_point(point_at(-1, 0, 1, 0, 1'b0, 1'b1));
      send_point(point_at(5, 5, 5, 65535, 1'b0, 1'b0));
      send_point(point_at(6, 6, 6, 0, 1'b0, 1'b1));
      wait_for_results();

      // Dimension above the maximum saturates, threshold at its top, scales at both ends.
      apply_settings(63, 131071, -32768, 32767, 0, 65535, 0, 1);
      send_point(point_at(32767, 32767, 32767, 65535, 1'b1, 1'b1));
      send_point(point_at(32767, 0, 32767, 1, 1'b0, 1'b0));
      send_point(point_at(0, -32768, 12345, 40000, 1'b0, 1'b0));
      send_point(point_at(-32768, 32767, -32768, 0, 1'b0, 1'b1));
      wait_for_results();

      // Back to the reset values, where nothing drops: top cell, one step past the grid.
      apply_settings(32, 0, 0, 0, 0, 256, 256, 256);
      send_point(point_at(31 * 256, 31 * 256, 31 * 256, 0, 1'b1, 1'b0));
      send_point(point_at(32 * 256, 0, 0, 0, 1'b0, 1'b0));
      send_point(point_at(0, 0, 0, 65535, 1'b0, 1'b1));
      wait_for_results();

      // Random phases. The sender pauses for every result at each phase boundary, since the
      // registers may only change while the unit is idle.
      for (phase_no = 0; phase_no < PHASES; phase_no++) begin
         if (phase_no == 3) begin
            send_idle_pct = 47;
            rcv_idle_pct = 6;
         end
         if (phase_no == 6) begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         pick_settings(phase_no);
         // With neither side idling, one long result stall fills the unit while requests
         // keep coming, so its request port has to stall.
         if (phase_no == 6) hold_requests <= hold_requests + 1;
         run_phase(ITEMS_PER_PHASE);
         wait_for_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d point requests and %0d results under %0d register settings.",
               sb.request_count, sb.result_count, settings_count);
      $display("Points kept %0d, dropped %0d, forced keeps %0d, register writes %0d.",
               sb.kept_seen, sb.dropped_seen, sb.forced_seen, sb.write_count);
      if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  sb.mismatch_count, sb.outstanding());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
